// ===== rtl/natw_pkg.sv =====
package natw_pkg;

   localparam int DIMENSIONS   = 3;
   localparam int COORD_WIDTH  = 32;
   localparam int OFFSET_WIDTH = COORD_WIDTH + 1;

   // Request tdata: all lows, then all highs, then all extents, byte padded.
   localparam int REQ_FIELD_BITS = 3 * DIMENSIONS * COORD_WIDTH;
   localparam int REQ_DATA_WIDTH = ((REQ_FIELD_BITS + 7) / 8) * 8;
   // Response tdata: all tile lows, then all tile highs, byte padded.
   localparam int RSP_FIELD_BITS = 2 * DIMENSIONS * COORD_WIDTH;
   localparam int RSP_DATA_WIDTH = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam logic OP_START = 1'b0;
   localparam logic OP_NEXT  = 1'b1;

   typedef logic [COORD_WIDTH-1:0]  coord_type;
   typedef logic [OFFSET_WIDTH-1:0] offset_type;
   typedef coord_type  [DIMENSIONS-1:0] coord_array_type;
   typedef offset_type [DIMENSIONS-1:0] offset_array_type;

   localparam coord_type COORD_ONE = coord_type'(1);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // capture box and extents, clear the cursor
      logic span;   // form box spans and extent-minus-one
      logic sum;    // form next cursor and raw tile top
      logic clip;   // clip tile top, find odometer wraps
      logic emit;   // load the response register, advance the cursor
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic empty;     // some box high lies below its low
      logic done;      // every dimension wraps: the walk ends on this tile
      logic out_busy;  // response register holds a tile not yet taken
   } status_type;

endpackage

// ===== rtl/natw_ctrl.sv =====
module natw_ctrl
   import natw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tuser,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_ACTIVE = 6'b000010,
      ST_LOAD   = 6'b000100,
      ST_SUM    = 6'b001000,
      ST_CLIP   = 6'b010000,
      ST_OUT    = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE) || (state_ff == ST_ACTIVE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_tuser == OP_START)) begin
               cmd.load = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_ACTIVE: begin
            if (accept) begin
               if (req_tuser == OP_START) begin
                  cmd.load = 1'b1;
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_SUM;
               end
            end
         end
         ST_LOAD: begin
            cmd.span = 1'b1;
            state_in = status.empty ? ST_IDLE : ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_CLIP;
         end
         ST_CLIP: begin
            cmd.clip = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!status.out_busy) begin
               cmd.emit = 1'b1;
               state_in = status.done ? ST_IDLE : ST_ACTIVE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/natw_datapath.sv =====
module natw_datapath
   import natw_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   input  coord_array_type           req_low,
   input  coord_array_type           req_high,
   input  coord_array_type           req_extent,
   output status_type                status,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic                      rsp_tlast
);

   coord_array_type  lo_ff, lo_in, hi_ff, hi_in, ext_ff, ext_in;
   coord_array_type  extm1_ff, extm1_in, span_ff, span_in, topc_ff, topc_in;
   offset_array_type cursor_ff, cursor_in, next_ff, next_in, top_ff, top_in;
   logic [DIMENSIONS-1:0]     wrap_ff, wrap_in;
   logic [RSP_DATA_WIDTH-1:0] data_ff, data_in;
   logic                      valid_ff, valid_in;
   logic                      last_ff, last_in;
   logic [DIMENSIONS-1:0]     below;

   always_comb begin : next_values
      logic carry;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      ext_in    = ext_ff;
      extm1_in  = extm1_ff;
      span_in   = span_ff;
      topc_in   = topc_ff;
      cursor_in = cursor_ff;
      next_in   = next_ff;
      top_in    = top_ff;
      wrap_in   = wrap_ff;
      data_in   = data_ff;
      last_in   = last_ff;
      carry     = 1'b1;

      for (int d = 0; d < DIMENSIONS; d++) begin
         below[d] = $signed(hi_ff[d]) < $signed(lo_ff[d]);
         if (cmd.load) begin
            lo_in[d]     = req_low[d];
            hi_in[d]     = req_high[d];
            // A zero extent walks like an extent of one.
            ext_in[d]    = (req_extent[d] == '0) ? COORD_ONE : req_extent[d];
            cursor_in[d] = '0;
         end
         if (cmd.span) begin
            span_in[d]  = hi_ff[d] - lo_ff[d];
            extm1_in[d] = ext_ff[d] - COORD_ONE;
         end
         if (cmd.sum) begin
            next_in[d] = cursor_ff[d] + {1'b0, ext_ff[d]};
            top_in[d]  = cursor_ff[d] + {1'b0, extm1_ff[d]};
         end
         if (cmd.clip) begin
            wrap_in[d] = next_ff[d] > {1'b0, span_ff[d]};
            topc_in[d] = (top_ff[d] > {1'b0, span_ff[d]}) ? span_ff[d]
                                                           : top_ff[d][COORD_WIDTH-1:0];
         end
      end

      if (cmd.emit) begin
         data_in = '0;
         for (int d = 0; d < DIMENSIONS; d++) begin
            data_in[d*COORD_WIDTH +: COORD_WIDTH] =
               lo_ff[d] + cursor_ff[d][COORD_WIDTH-1:0];
            data_in[(DIMENSIONS+d)*COORD_WIDTH +: COORD_WIDTH] = lo_ff[d] + topc_ff[d];
         end
         last_in = &wrap_ff;
         // Odometer step: the last dimension moves fastest, a wrap carries upward.
         for (int k = DIMENSIONS - 1; k >= 0; k--) begin
            if (carry) begin
               cursor_in[k] = wrap_ff[k] ? '0 : next_ff[k];
            end
            carry = carry & wrap_ff[k];
         end
      end
   end

   always_comb begin
      if (cmd.emit) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      ext_ff   <= ext_in;
      extm1_ff <= extm1_in;
      span_ff  <= span_in;
      topc_ff  <= topc_in;
      next_ff  <= next_in;
      top_ff   <= top_in;
      wrap_ff  <= wrap_in;
      data_ff  <= data_in;
      last_ff  <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         cursor_ff <= '0;
      end else begin
         valid_ff  <= valid_in;
         cursor_ff <= cursor_in;
      end
   end

   assign status.empty    = |below;
   assign status.done     = &wrap_ff;
   assign status.out_busy = valid_ff && !rsp_tready;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ===== rtl/nd_aligned_tile_walker.sv =====
// Channel  Direction  Contents
// req_     in         tuser: op (start or next); tdata: box lows, box highs, extents
// rsp_     out        tdata: tile lows, tile highs; tlast: final tile of the walk
//
// A start is loaded in its transfer cycle, then passes the span, sum, clip and emit steps
// before the tile sits in the response register; a next passes the sum, clip and emit steps.
// The steps follow the registered add, clip and odometer chain in the datapath.
// A next while idle is taken and gives nothing.
// Reset is synchronous and returns the walker to idle with an empty response register.
// A stalled response holds the emit step; the next request is taken while the last
// tile still waits in the response register.
module nd_aligned_tile_walker
   import natw_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // Fields from bit 0 up: box_low_0..2, box_high_0..2, extent_0..2.
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   // Fields from bit 0 up: op.
   input  logic                      req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // Fields from bit 0 up: tile_low_0..2, tile_high_0..2.
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic                      rsp_tlast
);

   cmd_type         cmd;
   status_type      status;
   coord_array_type req_low, req_high, req_extent;

   always_comb begin
      for (int d = 0; d < DIMENSIONS; d++) begin
         req_low[d]    = req_tdata[d*COORD_WIDTH +: COORD_WIDTH];
         req_high[d]   = req_tdata[(DIMENSIONS+d)*COORD_WIDTH +: COORD_WIDTH];
         req_extent[d] = req_tdata[(2*DIMENSIONS+d)*COORD_WIDTH +: COORD_WIDTH];
      end
   end

   natw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   natw_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_low    (req_low),
      .req_high   (req_high),
      .req_extent (req_extent),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // A start transfer always leads into the load step, so no request follows at once.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_START) |=> !req_tready)
      else $error("request taken right after a start transfer");

   // An emitted tile must show up on the response channel.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_tvalid)
      else $error("emitted tile missing from the response register");

   // After the final tile the walker is idle and ready for a request.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit && status.done |=> req_tready)
      else $error("walker not idle after the final tile");

   // The controller never emits over a tile that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !status.out_busy)
      else $error("response register overwritten");

endmodule

// ===== verif/tb_nd_aligned_tile_walker.sv =====
module tb_nd_aligned_tile_walker;
   import natw_pkg::*;

   localparam int RANDOM_ITEMS = 650;
   localparam int HOLD_OFF     = 80;
   localparam int QUIET_LIMIT  = 1000;
   localparam int MAX_NEXTS    = 24;
   localparam int DATA_BITS    = DIMENSIONS * COORD_WIDTH;

   localparam coord_type COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam coord_type COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam coord_type COORD_ALL = '1;

   typedef enum logic [1:0] {CHECK_MODEL, CHECK_NONE, CHECK_TILE} row_check_type;

   typedef struct packed {
      logic            op;
      coord_array_type lo;
      coord_array_type hi;
      coord_array_type ext;
   } walk_req_type;

   typedef struct packed {
      coord_array_type lo;
      coord_array_type hi;
      logic            last;
   } tile_type;

   typedef struct packed {
      walk_req_type  req;
      row_check_type how;
      tile_type      tile;
   } plan_row_type;

   localparam tile_type BLANK_TILE = '0;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata;
   logic                      req_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      rsp_tlast;

   // Walk state as the block should hold it.
   logic       walk_on;
   coord_type  box_lo [DIMENSIONS];
   coord_type  box_hi [DIMENSIONS];
   coord_type  step_len [DIMENSIONS];
   offset_type cursor [DIMENSIONS];

   tile_type     pending_tiles[$];
   plan_row_type plan[$];
   tile_type     want;
   tile_type     got;
   int           mismatches = 0;
   int           burst_left;
   int           quiet_cycles = 0;

   nd_aligned_tile_walker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic walk_req_type make_req(input logic op,
                                             input coord_type lo0, lo1, lo2,
                                             input coord_type hi0, hi1, hi2,
                                             input coord_type e0, e1, e2);
      walk_req_type r;
      r.op  = op;
      r.lo  = {lo2, lo1, lo0};
      r.hi  = {hi2, hi1, hi0};
      r.ext = {e2, e1, e0};
      return r;
   endfunction

   function automatic tile_type make_tile(input coord_type lo0, lo1, lo2,
                                          input coord_type hi0, hi1, hi2,
                                          input logic last);
      tile_type t;
      t.lo   = {lo2, lo1, lo0};
      t.hi   = {hi2, hi1, hi0};
      t.last = last;
      return t;
   endfunction

   // Appends one row to the directed table.
   function automatic void add_row(input walk_req_type req, input row_check_type how,
                                   input tile_type tile);
      plan_row_type row;
      row.req  = req;
      row.how  = how;
      row.tile = tile;
      plan.insert(plan.size(), row);
   endfunction

   // Queues one tile that the response channel should carry next.
   function automatic void expect_tile(input tile_type t);
      pending_tiles.insert(pending_tiles.size(), t);
   endfunction

   // Applies one request to the walk state; returns 1 with the tile when one is due.
   function automatic logic walker_step(input walk_req_type r, output tile_type t);
      coord_type                span;
      logic [COORD_WIDTH+1:0]   reach;
      logic                     carry;
      t = BLANK_TILE;
      if (r.op == OP_START) begin
         walk_on = 1'b1;
         for (int d = 0; d < DIMENSIONS; d++) begin
            box_lo[d]   = r.lo[d];
            box_hi[d]   = r.hi[d];
            step_len[d] = (r.ext[d] == '0) ? COORD_ONE : r.ext[d];
            cursor[d]   = '0;
            if ($signed(r.hi[d]) < $signed(r.lo[d])) begin
               walk_on = 1'b0;
            end
         end
         if (!walk_on) begin
            return 1'b0;
         end
      end else if (!walk_on) begin
         return 1'b0;
      end
      for (int d = 0; d < DIMENSIONS; d++) begin
         span  = box_hi[d] - box_lo[d];
         reach = {1'b0, cursor[d]} + {2'b00, step_len[d]} - (COORD_WIDTH+2)'(1);
         if (reach > {2'b00, span}) begin
            reach = {2'b00, span};
         end
         t.lo[d] = box_lo[d] + cursor[d][COORD_WIDTH-1:0];
         t.hi[d] = box_lo[d] + reach[COORD_WIDTH-1:0];
      end
      // Odometer step, last dimension fastest; a carry out of dimension 0 ends the walk.
      carry = 1'b1;
      for (int d = DIMENSIONS - 1; d >= 0; d--) begin
         if (carry) begin
            span  = box_hi[d] - box_lo[d];
            reach = {1'b0, cursor[d]} + {2'b00, step_len[d]};
            if (reach > {2'b00, span}) begin
               cursor[d] = '0;
            end else begin
               cursor[d] = reach[OFFSET_WIDTH-1:0];
               carry     = 1'b0;
            end
         end
      end
      t.last = carry;
      if (carry) begin
         walk_on = 1'b0;
      end
      return 1'b1;
   endfunction

   // Offers one request in bursts with random gaps, then records what it should produce.
   task automatic send(input walk_req_type r, input row_check_type how, input tile_type typed);
      tile_type t;
      logic     has_tile;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= r.op;
      req_tdata  <= REQ_DATA_WIDTH'({r.ext, r.hi, r.lo});
      do @(posedge clock); while (!req_tready);
      has_tile = walker_step(r, t);
      case (how)
         CHECK_MODEL: begin
            if (has_tile) begin
               expect_tile(t);
            end
         end
         CHECK_TILE: expect_tile(typed);
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.lo   = rsp_tdata[0 +: DATA_BITS];
         got.hi   = rsp_tdata[DATA_BITS +: DATA_BITS];
         got.last = rsp_tlast;
         if (pending_tiles.size() == 0) begin
            $error("tile transfer with none expected: low %h high %h last %b",
                   got.lo, got.hi, got.last);
            mismatches++;
         end else begin
            want = pending_tiles.pop_front();
            for (int d = 0; d < DIMENSIONS; d++) begin
               if (got.lo[d] !== want.lo[d]) begin
                  $error("tile_low_%0d: expected %h, got %h", d, want.lo[d], got.lo[d]);
                  mismatches++;
               end
               if (got.hi[d] !== want.hi[d]) begin
                  $error("tile_high_%0d: expected %h, got %h", d, want.hi[d], got.hi[d]);
                  mismatches++;
               end
            end
            if (got.last !== want.last) begin
               $error("last_tile: expected %b, got %b", want.last, got.last);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("tb_nd_aligned_tile_walker: FAIL");
         $finish;
      end
   end

   // Receiver: stretches of steady, random, mostly stalled and alternating acceptance, plus one long
   // hold-off while the sender keeps offering requests.
   initial begin
      int mode;
      int stretch;
      int rx_cycles;
      bit held;
      rsp_tready <= 1'b0;
      rx_cycles = 0;
      held      = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (!held && rx_cycles >= 250) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF) @(posedge clock);
            held = 1'b1;
         end
         mode    = $urandom_range(0, 3);
         stretch = $urandom_range(10, 60);
         rx_cycles += stretch;
         repeat (stretch) begin
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= $urandom_range(0, 1);
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ~rsp_tready;
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin
      walk_req_type     r;
      walk_req_type     next_req;
      longint unsigned  tiles;
      longint unsigned  span64;
      longint unsigned  len64;
      int               nexts;
      int               sent;
      bit               empty;

      reset        <= 1'b1;
      req_tvalid   <= 1'b0;
      req_tuser    <= OP_NEXT;
      req_tdata    <= '0;
      burst_left   = 0;
      walk_on      = 1'b0;
      for (int d = 0; d < DIMENSIONS; d++) begin
         box_lo[d]   = '0;
         box_hi[d]   = '0;
         step_len[d] = COORD_ONE;
         cursor[d]   = '0;
      end

      // The payload of a next is ignored, so it carries all ones.
      next_req    = '1;
      next_req.op = OP_NEXT;

      // Next while idle after reset, then single-tile walks at zero and at the coordinate extremes.
      add_row(next_req, CHECK_NONE, BLANK_TILE);
      add_row(make_req(OP_START, 0, 0, 0, 0, 0, 0, 1, 1, 1), CHECK_TILE,
              make_tile(0, 0, 0, 0, 0, 0, 1'b1));
      add_row(make_req(OP_START, COORD_MIN, COORD_MIN, COORD_MIN,
                       COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0), CHECK_TILE,
              make_tile(COORD_MIN, COORD_MIN, COORD_MIN,
                        COORD_MIN, COORD_MIN, COORD_MIN, 1'b1));
      add_row(make_req(OP_START, COORD_MAX, COORD_MAX, COORD_MAX,
                       COORD_MAX, COORD_MAX, COORD_MAX,
                       COORD_ALL, COORD_ALL, COORD_ALL), CHECK_TILE,
              make_tile(COORD_MAX, COORD_MAX, COORD_MAX,
                        COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
      // Full coordinate range split in halves: the offsets overflow the coordinate width.
      add_row(make_req(OP_START, COORD_MIN, COORD_MIN, COORD_MIN,
                       COORD_MAX, COORD_MAX, COORD_MAX,
                       COORD_MIN, COORD_MIN, COORD_MIN), CHECK_MODEL, BLANK_TILE);
      repeat (7) add_row(next_req, CHECK_MODEL, BLANK_TILE);
      // A walk cut short by a new start, which then runs to its end.
      add_row(make_req(OP_START, 1, -3, 5, 2, -2, 9, 0, 1, 3), CHECK_MODEL, BLANK_TILE);
      repeat (2) add_row(next_req, CHECK_MODEL, BLANK_TILE);
      add_row(make_req(OP_START, -1, -1, -1, 0, 0, 1, COORD_ALL, 1, 1),
              CHECK_MODEL, BLANK_TILE);
      repeat (5) add_row(next_req, CHECK_MODEL, BLANK_TILE);
      add_row(next_req, CHECK_NONE, BLANK_TILE);
      // An empty box drops a walk in progress.
      add_row(make_req(OP_START, 1, -3, 5, 2, -2, 9, 0, 1, 3), CHECK_MODEL, BLANK_TILE);
      add_row(make_req(OP_START, 0, 5, 0, 3, 4, 3, 1, 1, 1), CHECK_NONE, BLANK_TILE);
      add_row(next_req, CHECK_NONE, BLANK_TILE);
      add_row(make_req(OP_START, 0, 0, COORD_MAX, 0, 0, COORD_MIN, 1, 1, 1),
              CHECK_NONE, BLANK_TILE);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         send(plan[i].req, plan[i].how, plan[i].tile);
      end

      // Random walks: mostly small boxes run to their end, some cut short, a few empty.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         r.op  = OP_START;
         tiles = 1;
         empty = 1'b0;
         for (int d = 0; d < DIMENSIONS; d++) begin
            r.lo[d] = ($urandom_range(0, 9) < 6) ? coord_type'($urandom)
                                                 : coord_type'($urandom_range(0, 16) - 8);
            case ($urandom_range(0, 19))
               0: r.hi[d] = coord_type'($urandom);
               1: r.hi[d] = r.lo[d] - coord_type'($urandom_range(1, 3));
               default: r.hi[d] = r.lo[d] + coord_type'($urandom_range(0, 5));
            endcase
            case ($urandom_range(0, 9))
               0: r.ext[d] = '0;
               1: r.ext[d] = coord_type'($urandom);
               default: r.ext[d] = coord_type'($urandom_range(1, 3));
            endcase
            if ($signed(r.hi[d]) < $signed(r.lo[d])) begin
               empty = 1'b1;
            end
            span64 = 64'(coord_type'(r.hi[d] - r.lo[d]));
            len64  = (r.ext[d] == '0) ? 64'd1 : 64'(r.ext[d]);
            tiles  = tiles * ((span64 + len64) / len64);
         end
         send(r, CHECK_MODEL, BLANK_TILE);
         sent++;
         if (empty) begin
            nexts = 0;
         end else if (tiles - 1 > MAX_NEXTS) begin
            nexts = $urandom_range(0, MAX_NEXTS);
         end else if ($urandom_range(0, 5) == 0) begin
            nexts = $urandom_range(0, int'(tiles - 1));
         end else begin
            nexts = int'(tiles - 1);
         end
         repeat (nexts) begin
            r.op  = OP_NEXT;
            r.lo  = {$urandom, $urandom, $urandom};
            r.hi  = {$urandom, $urandom, $urandom};
            r.ext = {$urandom, $urandom, $urandom};
            send(r, CHECK_MODEL, BLANK_TILE);
            sent++;
         end
         // Now and then a next that finds the walker idle or a walk to carry on.
         if ($urandom_range(0, 3) == 0) begin
            send(next_req, CHECK_MODEL, BLANK_TILE);
         end
      end
      req_tvalid <= 1'b0;

      while (pending_tiles.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_nd_aligned_tile_walker: PASS");
      end else begin
         $display("tb_nd_aligned_tile_walker: FAIL");
      end
      $finish;
   end

endmodule
